// ===== rtl/lpl_pkg.sv =====
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared types and constants of the leveling peak limiter.
// ----------------------------------------------------------------------------
package lpl_pkg;

  typedef struct packed {
    logic start;
    logic blk;
    logic adapt;
    logic go;
  } lane_ctl_t;

  typedef struct packed {
    logic req_valid;
    logic done;
  } lane_sts_t;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_ATTACK    = 3'd1;
  localparam logic [2:0] REG_RELEASE   = 3'd2;
  localparam logic [2:0] REG_ENVELOPE  = 3'd3;
  localparam logic [2:0] REG_LINK      = 3'd4;
  localparam logic [2:0] REG_ADAPTIVE  = 3'd5;
  localparam logic [2:0] REG_CHANNELS  = 3'd6;

  localparam int RELEASE_RESET  = 16760000;
  localparam int ENVELOPE_RESET = 16776500;

  localparam int L16_W = 21;
  localparam int DB_W  = 24;
  localparam int W_W   = 17;

  localparam logic [18:0]      DB_PER_LOG2   = 19'd394566;
  localparam logic [DB_W-1:0]  HALF_DB       = 24'd32768;
  localparam logic [DB_W-1:0]  FULL_W_DB     = 24'd393216;
  // weight = db / 6 as a reciprocal multiply, exact for db below 2^19
  localparam logic [17:0]      W_RECIP       = 18'd174763;
  localparam int               W_RECIP_SHIFT = 20;
  localparam logic [W_W-1:0]   W_ONE         = 17'h10000;
  localparam logic [8:0]       LINK_FULL     = 9'd256;
  localparam logic [3:0]       GAIN_FLOOR    = 4'd8;

endpackage

// ===== rtl/lpl_lane.sv =====
// ----------------------------------------------------------------------------
// lpl_lane
// One channel of the limiter: release latch, required gain divider,
// envelope and gain smoothing on a shared multiplier, output scaling.
// ----------------------------------------------------------------------------
module lpl_lane #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEFF_BITS  = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpl_pkg::lane_ctl_t            ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0]        thresh,
  input  logic [COEFF_BITS-1:0]         attack,
  input  logic [COEFF_BITS-1:0]         rel_coeff,
  input  logic [COEFF_BITS-1:0]         env_coeff,
  input  logic [SAMPLE_BITS-1:0]        req_link,
  output lpl_pkg::lane_sts_t            sts,
  output logic [SAMPLE_BITS-1:0]        req,
  output logic [SAMPLE_BITS-1:0]        gain,
  output logic [SAMPLE_BITS-1:0]        y
);

  localparam int S    = SAMPLE_BITS;
  localparam int C    = COEFF_BITS;
  localparam int MW0  = (S > C + 1) ? S : C + 1;
  localparam int MW   = (MW0 > lpl_pkg::L16_W) ? MW0 : lpl_pkg::L16_W;
  localparam int PW   = 2 * MW;
  localparam int CNTW = $clog2(S);
  localparam int GW   = PW + 1 - C;
  localparam logic [S-1:0] UNITY = {1'b1, {(S-1){1'b0}}};
  localparam logic [C:0]   CONE  = {1'b1, {C{1'b0}}};

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_NORM  = 5'd1;
  localparam logic [4:0] ST_DB    = 5'd2;
  localparam logic [4:0] ST_DBCHK = 5'd3;
  localparam logic [4:0] ST_WDIV  = 5'd4;
  localparam logic [4:0] ST_RR    = 5'd5;
  localparam logic [4:0] ST_RA    = 5'd6;
  localparam logic [4:0] ST_RB    = 5'd7;
  localparam logic [4:0] ST_RSUM  = 5'd8;
  localparam logic [4:0] ST_REQ   = 5'd9;
  localparam logic [4:0] ST_QDIV  = 5'd10;
  localparam logic [4:0] ST_HOLD  = 5'd11;
  localparam logic [4:0] ST_E1    = 5'd12;
  localparam logic [4:0] ST_E2    = 5'd13;
  localparam logic [4:0] ST_E3    = 5'd14;
  localparam logic [4:0] ST_G1    = 5'd15;
  localparam logic [4:0] ST_G2    = 5'd16;
  localparam logic [4:0] ST_G3    = 5'd17;
  localparam logic [4:0] ST_O1    = 5'd18;
  localparam logic [4:0] ST_O2    = 5'd19;
  localparam logic [4:0] ST_DONE  = 5'd20;

  logic [4:0]   state_r, state_nxt;
  logic [S-1:0] g_r, env_r;
  logic [C-1:0] act_r;

  logic [S-1:0]             mag_r, req_r, t_r, y_r;
  logic                     neg_r, sel_r;
  logic [CNTW-1:0]          sh_r, cnt_r;
  logic [lpl_pkg::L16_W-1:0] l16_r;
  logic [lpl_pkg::W_W-1:0]  w_r;
  logic [C-1:0]             rr_r;
  logic [PW-1:0]            prod_r, acc_r;
  logic [S-1:0]             dv_rem_r, dv_low_r, dv_div_r, dv_q_r;

  logic [MW-1:0]            mul_a, mul_b;
  logic [PW:0]              sum;
  logic [GW-1:0]            gv;
  logic [S-1:0]             g_clamp;
  logic [S:0]               dv_t;
  logic                     dv_ge;
  logic [S-1:0]             dv_rem_nxt, dv_q_nxt;
  logic                     dv_last;
  logic [S+14:0]            frac_ext;
  logic [lpl_pkg::L16_W-1:0] l16_nxt;
  logic [lpl_pkg::DB_W-1:0] db;
  logic [S-1:0]             abs_x, m;
  logic                     latch_path, g_sel;
  logic [C-1:0]             g_coef;

  assign sum = {1'b0, acc_r} + {1'b0, prod_r};
  assign gv  = sum[PW:C];

  always_comb begin
    if (gv < GW'(lpl_pkg::GAIN_FLOOR)) begin
      g_clamp = S'(lpl_pkg::GAIN_FLOOR);
    end else if (gv > GW'(UNITY)) begin
      g_clamp = UNITY;
    end else begin
      g_clamp = gv[S-1:0];
    end
  end

  assign dv_t       = {dv_rem_r, dv_low_r[S-1]};
  assign dv_ge      = dv_t >= {1'b0, dv_div_r};
  assign dv_rem_nxt = dv_ge ? dv_t[S-1:0] - dv_div_r : dv_t[S-1:0];
  assign dv_q_nxt   = {dv_q_r[S-2:0], dv_ge};
  assign dv_last    = cnt_r == CNTW'(S - 1);

  assign frac_ext = {t_r[S-2:0], 16'b0};
  assign l16_nxt  = {5'(sh_r), 16'b0} - {5'b0, frac_ext[S+14 -: 16]};
  assign db       = prod_r[16 +: lpl_pkg::DB_W];

  assign abs_x = sample[S-1] ? S'(~sample + 1'b1) : S'(sample);
  assign m     = prod_r[S-1 +: S];
  assign latch_path = ctl.blk && ctl.adapt && !env_r[S-1];
  assign g_sel  = req_r < g_r;
  assign g_coef = sel_r ? attack : act_r;

  // multiplier operand select
  always_comb begin
    case (state_r)
      ST_DB: begin
        mul_a = MW'(l16_r);
        mul_b = MW'(lpl_pkg::DB_PER_LOG2);
      end
      ST_DBCHK: begin
        mul_a = MW'(db);
        mul_b = MW'(lpl_pkg::W_RECIP);
      end
      ST_RR: begin
        mul_a = MW'(rel_coeff);
        mul_b = MW'(rel_coeff);
      end
      ST_RA: begin
        mul_a = MW'(rel_coeff);
        mul_b = MW'(lpl_pkg::W_ONE - w_r);
      end
      ST_RB: begin
        mul_a = MW'(rr_r);
        mul_b = MW'(w_r);
      end
      ST_E1: begin
        mul_a = MW'(env_r);
        mul_b = MW'(env_coeff);
      end
      ST_E2: begin
        mul_a = MW'(req_r);
        mul_b = MW'(CONE - {1'b0, env_coeff});
      end
      ST_G1: begin
        mul_a = MW'(g_r);
        mul_b = MW'(g_sel ? attack : act_r);
      end
      ST_G2: begin
        mul_a = MW'(sel_r ? req_r : UNITY);
        mul_b = MW'(CONE - {1'b0, g_coef});
      end
      ST_O1: begin
        mul_a = MW'(mag_r);
        mul_b = MW'(g_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE, ST_DONE: begin
        if (ctl.start) begin
          if (latch_path) begin
            state_nxt = (env_r == '0) ? ST_RR : ST_NORM;
          end else begin
            state_nxt = ST_REQ;
          end
        end
      end
      ST_NORM:  if (t_r[S-1]) state_nxt = ST_DB;
      ST_DB:    state_nxt = ST_DBCHK;
      ST_DBCHK: begin
        if (db <= lpl_pkg::HALF_DB) begin
          state_nxt = ST_REQ;
        end else if (db >= lpl_pkg::FULL_W_DB) begin
          state_nxt = ST_RR;
        end else begin
          state_nxt = ST_WDIV;
        end
      end
      ST_WDIV:  state_nxt = ST_RR;
      ST_RR:    state_nxt = ST_RA;
      ST_RA:    state_nxt = ST_RB;
      ST_RB:    state_nxt = ST_RSUM;
      ST_RSUM:  state_nxt = ST_REQ;
      ST_REQ:   state_nxt = (mag_r > thresh) ? ST_QDIV : ST_HOLD;
      ST_QDIV:  if (dv_last) state_nxt = ST_HOLD;
      ST_HOLD:  if (ctl.go) state_nxt = ctl.adapt ? ST_E1 : ST_G1;
      ST_E1:    state_nxt = ST_E2;
      ST_E2:    state_nxt = ST_E3;
      ST_E3:    state_nxt = ST_G1;
      ST_G1:    state_nxt = ST_G2;
      ST_G2:    state_nxt = ST_G3;
      ST_G3:    state_nxt = ST_O1;
      ST_O1:    state_nxt = ST_O2;
      ST_O2:    state_nxt = ST_DONE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      g_r     <= UNITY;
      env_r   <= UNITY;
      act_r   <= C'(lpl_pkg::RELEASE_RESET);
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE, ST_DONE: begin
          if (ctl.start && ctl.blk && !latch_path) begin
            act_r <= rel_coeff;
          end
        end
        ST_DBCHK: if (db <= lpl_pkg::HALF_DB) act_r <= rel_coeff;
        ST_RSUM:  act_r <= sum[16 +: C];
        ST_E3:    env_r <= sum[C +: S];
        ST_G3:    g_r   <= g_clamp;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE, ST_DONE: begin
        if (ctl.start) begin
          mag_r <= abs_x;
          neg_r <= sample[S-1];
          t_r   <= env_r;
          sh_r  <= '0;
          w_r   <= lpl_pkg::W_ONE;
        end
      end
      ST_NORM: begin
        if (t_r[S-1]) begin
          l16_r <= l16_nxt;
        end else begin
          t_r  <= {t_r[S-2:0], 1'b0};
          sh_r <= sh_r + 1'b1;
        end
      end
      ST_WDIV: w_r <= prod_r[lpl_pkg::W_RECIP_SHIFT +: lpl_pkg::W_W];
      ST_QDIV: begin
        dv_rem_r <= dv_rem_nxt;
        dv_low_r <= {dv_low_r[S-2:0], 1'b0};
        dv_q_r   <= dv_q_nxt;
        cnt_r    <= cnt_r + 1'b1;
        if (dv_last) req_r <= dv_q_nxt;
      end
      ST_RA:   rr_r  <= prod_r[C +: C];
      ST_RB:   acc_r <= prod_r;
      ST_REQ: begin
        dv_rem_r <= {1'b0, thresh[S-1:1]};
        dv_low_r <= {thresh[0], {(S-1){1'b0}}};
        dv_div_r <= mag_r;
        dv_q_r   <= '0;
        cnt_r    <= '0;
        if (!(mag_r > thresh)) req_r <= UNITY;
      end
      ST_HOLD: if (ctl.go) req_r <= req_link;
      ST_E2:   acc_r <= prod_r;
      ST_G1:   sel_r <= g_sel;
      ST_G2:   acc_r <= prod_r;
      ST_O2:   y_r   <= neg_r ? S'(~m + 1'b1) : m;
      default: begin
      end
    endcase
  end

  assign sts.req_valid = state_r == ST_HOLD;
  assign sts.done      = state_r == ST_DONE;
  assign req  = req_r;
  assign gain = g_r;
  assign y    = y_r;

endmodule

// ===== rtl/leveling_peak_limiter.sv =====
// ----------------------------------------------------------------------------
// leveling_peak_limiter
// Stereo feed-forward peak limiter with channel linking and adaptive release.
// ----------------------------------------------------------------------------
// One frame at a time. Each channel has its own lane that divides threshold by
// magnitude one quotient bit per cycle and runs the smoothing on one shared
// multiplier. A lane divides only when a sample is over the threshold, runs
// the envelope smoothing only with adaptive release on, then gain smoothing
// and output scaling; in stereo the slower lane sets the pace of the load. On
// a block start with adaptive release and the envelope under unity, the
// leading-one search and the release blend can come first. The next frame is
// taken in the cycle after the load. The result waits in an output register,
// and the next frame is taken while it waits; a second result that meets a
// stalled output holds the input stalled until the first one leaves.
module leveling_peak_limiter #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEFF_BITS  = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_left,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_right,
  input  logic                          in_block_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic [SAMPLE_BITS-1:0]        out_frame_min_gain,
  output logic [SAMPLE_BITS-1:0]        out_block_min_gain
);

  localparam int S = SAMPLE_BITS;
  localparam int C = COEFF_BITS;
  localparam logic [S-1:0] UNITY = {1'b1, {(S-1){1'b0}}};

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_REQ  = 2'd1;
  localparam logic [1:0] T_RUN  = 2'd2;

  logic [S-1:0] thr_r;
  logic [C-1:0] atk_r, rel_r, envc_r;
  logic [8:0]   link_r;
  logic         adapt_r;
  logic [1:0]   chan_r;

  logic [1:0]   state_r;
  logic         blk_r, out_valid_r, bmin_valid_r;
  logic [S-1:0] bmin_r;
  logic [S-1:0] out_l_r, out_r_r, out_f_r, out_b_r;

  logic         wr, accept, stereo, go, all_done, load;
  logic [8:0]   link_sat;
  logic [S-1:0] req0, req1, g0, g1, y0, y1, mn, lk0, lk1;
  logic [S-1:0] fmin, bbase, bnew;
  logic [S+8:0] p0, p1;
  lpl_pkg::lane_ctl_t ctl0, ctl1;
  lpl_pkg::lane_sts_t sts0, sts1;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= UNITY;
      atk_r   <= '0;
      rel_r   <= C'(lpl_pkg::RELEASE_RESET);
      envc_r  <= C'(lpl_pkg::ENVELOPE_RESET);
      link_r  <= '0;
      adapt_r <= 1'b0;
      chan_r  <= 2'd2;
    end else if (wr) begin
      case (paddr[4:2])
        lpl_pkg::REG_THRESHOLD: thr_r   <= pwdata[S-1:0];
        lpl_pkg::REG_ATTACK:    atk_r   <= pwdata[C-1:0];
        lpl_pkg::REG_RELEASE:   rel_r   <= pwdata[C-1:0];
        lpl_pkg::REG_ENVELOPE:  envc_r  <= pwdata[C-1:0];
        lpl_pkg::REG_LINK:      link_r  <= pwdata[8:0];
        lpl_pkg::REG_ADAPTIVE:  adapt_r <= pwdata[0];
        lpl_pkg::REG_CHANNELS:  chan_r  <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      lpl_pkg::REG_THRESHOLD: prdata = 32'(thr_r);
      lpl_pkg::REG_ATTACK:    prdata = 32'(atk_r);
      lpl_pkg::REG_RELEASE:   prdata = 32'(rel_r);
      lpl_pkg::REG_ENVELOPE:  prdata = 32'(envc_r);
      lpl_pkg::REG_LINK:      prdata = 32'(link_r);
      lpl_pkg::REG_ADAPTIVE:  prdata = 32'(adapt_r);
      lpl_pkg::REG_CHANNELS:  prdata = 32'(chan_r);
      default:                prdata = '0;
    endcase
  end

  assign stereo   = chan_r[1];
  assign in_stall = state_r != T_IDLE;
  assign accept   = in_valid && !in_stall;
  assign go       = (state_r == T_REQ) && sts0.req_valid && (sts1.req_valid || !stereo);
  assign all_done = sts0.done && (sts1.done || !stereo);
  assign load     = (state_r == T_RUN) && all_done && !(out_valid_r && out_stall);

  assign ctl0 = '{start: accept, blk: in_block_start, adapt: adapt_r, go: go};
  assign ctl1 = '{start: accept && stereo, blk: in_block_start, adapt: adapt_r,
                  go: go && stereo};

  // channel link toward the smaller required gain
  assign link_sat = (link_r > lpl_pkg::LINK_FULL) ? lpl_pkg::LINK_FULL : link_r;
  assign mn  = (req0 < req1) ? req0 : req1;
  assign p0  = (S+9)'(req0 - mn) * (S+9)'(link_sat);
  assign p1  = (S+9)'(req1 - mn) * (S+9)'(link_sat);
  assign lk0 = stereo ? req0 - p0[8 +: S] : req0;
  assign lk1 = req1 - p1[8 +: S];

  lpl_lane #(.SAMPLE_BITS(S), .COEFF_BITS(C)) u_lane0 (
    .clk, .rst_n, .ctl(ctl0), .sample(in_sample_left), .thresh(thr_r),
    .attack(atk_r), .rel_coeff(rel_r), .env_coeff(envc_r), .req_link(lk0),
    .sts(sts0), .req(req0), .gain(g0), .y(y0)
  );

  lpl_lane #(.SAMPLE_BITS(S), .COEFF_BITS(C)) u_lane1 (
    .clk, .rst_n, .ctl(ctl1), .sample(in_sample_right), .thresh(thr_r),
    .attack(atk_r), .rel_coeff(rel_r), .env_coeff(envc_r), .req_link(lk1),
    .sts(sts1), .req(req1), .gain(g1), .y(y1)
  );

  assign fmin  = (stereo && g1 < g0) ? g1 : g0;
  assign bbase = (blk_r || !bmin_valid_r) ? UNITY : bmin_r;
  assign bnew  = (fmin < bbase) ? fmin : bbase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      out_valid_r  <= 1'b0;
      bmin_valid_r <= 1'b0;
    end else begin
      case (state_r)
        T_IDLE:  if (accept) state_r <= T_REQ;
        T_REQ:   if (go) state_r <= T_RUN;
        T_RUN:   if (load) state_r <= T_IDLE;
        default: state_r <= T_IDLE;
      endcase
      if (load) begin
        out_valid_r  <= 1'b1;
        bmin_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) blk_r <= in_block_start;
    if (load) begin
      bmin_r  <= bnew;
      out_l_r <= y0;
      out_r_r <= stereo ? y1 : '0;
      out_f_r <= fmin;
      out_b_r <= bnew;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left           = out_l_r;
  assign out_right          = out_r_r;
  assign out_frame_min_gain = out_f_r;
  assign out_block_min_gain = out_b_r;

endmodule
